// ----- hw/rtl/spom_pkg.sv -----
// shared types and constants for the spiral order matrix reader
`timescale 1ns / 1ps

package spom_pkg;

    // matrix bounds used as parameter defaults
    localparam int MAX_ROWS_DEF = 8;
    localparam int MAX_COLS_DEF = 8;

    // field and register widths
    localparam int VALUE_W   = 32;
    localparam int DIM_W     = 4;
    localparam int PROD_W    = 2 * DIM_W;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'd1;

    // register reset values
    localparam logic [DIM_W-1:0] ROW_COUNT_RST    = 4'd4;
    localparam logic [DIM_W-1:0] COLUMN_COUNT_RST = 4'd4;

    // top level sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_READ,
        ST_SHOW
    } t_state;

    // direction of travel along the current ring
    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT,
        DIR_UP
    } t_dir;

    // controls from the sequencer to the spiral walker
    typedef struct packed {
        logic start;
        logic step;
    } t_walk_ctrl;

endpackage

// ----- hw/rtl/spom_if.sv -----
// stream interfaces for matrix elements in and spiral results out
`timescale 1ns / 1ps

interface spom_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [spom_pkg::VALUE_W-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface spom_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [spom_pkg::VALUE_W-1:0] out_value;
    logic                                out_last;

    modport source (output valid, output out_value, output out_last, input ready);
    modport sink   (input valid, input out_value, input out_last, output ready);
endinterface

// ----- hw/rtl/spom_store.sv -----
// matrix element memory, one write port and one registered read port
`timescale 1ns / 1ps

module spom_store #(
    parameter int DEPTH = spom_pkg::MAX_ROWS_DEF * spom_pkg::MAX_COLS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [spom_pkg::VALUE_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [spom_pkg::VALUE_W-1:0] o_rdata
);

    logic [spom_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [spom_pkg::VALUE_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/spom_walker.sv -----
// spiral walker: ring bounds, position and one shared address adder
`timescale 1ns / 1ps

module spom_walker #(
    parameter int MAX_ROWS = spom_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = spom_pkg::MAX_COLS_DEF,
    parameter int AW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1,
    parameter int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    parameter int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  spom_pkg::t_walk_ctrl i_ctrl,
    input  logic [RW-1:0]        i_rmax,
    input  logic [CW-1:0]        i_cmax,
    input  logic [AW-1:0]        i_cols,
    output logic [AW-1:0]        o_addr,
    output logic                 o_last
);

    spom_pkg::t_dir r_dir, n_dir;
    logic [RW-1:0]  r_row, n_row, r_rmin, n_rmin, r_rmax, n_rmax;
    logic [CW-1:0]  r_col, n_col, r_cmin, n_cmin, r_cmax, n_cmax;
    logic [AW-1:0]  r_addr, n_addr, r_ring_addr, n_ring_addr;
    logic [AW-1:0]  r_cols, r_cols_neg, r_cols_p1;

    logic [RW-1:0]  row_span, row_off;
    logic [CW-1:0]  col_span;
    logic           ring_more, ring_end;
    logic [AW-1:0]  add_a, add_b, add_sum;

    // ring geometry
    assign row_span  = r_rmax - r_rmin;
    assign col_span  = r_cmax - r_cmin;
    assign row_off   = r_row - r_rmin;
    assign ring_more = (row_span > RW'(1)) && (col_span > CW'(1));

    // end of the current ring in the current direction
    always_comb begin
        case (r_dir)
            spom_pkg::DIR_RIGHT: ring_end = (r_col == r_cmax) && (r_row == r_rmax);
            spom_pkg::DIR_DOWN:  ring_end = (r_row == r_rmax) && (r_col == r_cmin);
            spom_pkg::DIR_LEFT:  ring_end = (r_col == r_cmin) && (row_off <= RW'(1));
            spom_pkg::DIR_UP:    ring_end = (row_off <= RW'(1));
            default:             ring_end = 1'b1;
        endcase
    end

    assign o_last = ring_end && !ring_more;
    assign o_addr = r_addr;

    // shared address adder
    assign add_sum = add_a + add_b;

    // next position along the spiral
    always_comb begin
        n_dir       = r_dir;
        n_row       = r_row;
        n_col       = r_col;
        n_rmin      = r_rmin;
        n_rmax      = r_rmax;
        n_cmin      = r_cmin;
        n_cmax      = r_cmax;
        n_ring_addr = r_ring_addr;
        add_a       = r_addr;
        add_b       = AW'(1);
        if (ring_end) begin
            // step into the next inner ring
            n_rmin      = r_rmin + RW'(1);
            n_rmax      = r_rmax - RW'(1);
            n_cmin      = r_cmin + CW'(1);
            n_cmax      = r_cmax - CW'(1);
            n_row       = r_rmin + RW'(1);
            n_col       = r_cmin + CW'(1);
            n_dir       = spom_pkg::DIR_RIGHT;
            add_a       = r_ring_addr;
            add_b       = r_cols_p1;
            n_ring_addr = add_sum;
        end else begin
            case (r_dir)
                spom_pkg::DIR_RIGHT: begin
                    if (r_col < r_cmax) begin
                        n_col = r_col + CW'(1);
                        add_b = AW'(1);
                    end else begin
                        n_dir = spom_pkg::DIR_DOWN;
                        n_row = r_row + RW'(1);
                        add_b = r_cols;
                    end
                end
                spom_pkg::DIR_DOWN: begin
                    if (r_row < r_rmax) begin
                        n_row = r_row + RW'(1);
                        add_b = r_cols;
                    end else begin
                        n_dir = spom_pkg::DIR_LEFT;
                        n_col = r_col - CW'(1);
                        add_b = '1;
                    end
                end
                spom_pkg::DIR_LEFT: begin
                    if (r_col > r_cmin) begin
                        n_col = r_col - CW'(1);
                        add_b = '1;
                    end else begin
                        n_dir = spom_pkg::DIR_UP;
                        n_row = r_row - RW'(1);
                        add_b = r_cols_neg;
                    end
                end
                default: begin
                    n_row = r_row - RW'(1);
                    add_b = r_cols_neg;
                end
            endcase
        end
        n_addr = add_sum;
    end

    // walker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= spom_pkg::DIR_RIGHT;
        end else if (i_ctrl.start) begin
            r_dir       <= spom_pkg::DIR_RIGHT;
            r_row       <= '0;
            r_col       <= '0;
            r_rmin      <= '0;
            r_cmin      <= '0;
            r_rmax      <= i_rmax;
            r_cmax      <= i_cmax;
            r_addr      <= '0;
            r_ring_addr <= '0;
            r_cols      <= i_cols;
            r_cols_neg  <= '0 - i_cols;
            r_cols_p1   <= i_cols + AW'(1);
        end else if (i_ctrl.step) begin
            r_dir       <= n_dir;
            r_row       <= n_row;
            r_col       <= n_col;
            r_rmin      <= n_rmin;
            r_rmax      <= n_rmax;
            r_cmin      <= n_cmin;
            r_cmax      <= n_cmax;
            r_addr      <= n_addr;
            r_ring_addr <= n_ring_addr;
        end
    end

endmodule

// ----- hw/rtl/spiral_order_matrix_reader_top.sv -----
// Load: one element per cycle, ready high while loading.
// After the element that fills the matrix, each result in spiral order is read from memory
// in the read state, then held valid in the show state until the sink takes it;
// no new elements are accepted until the last result is out.
// Reset: synchronous active low, clears the load count and sequencer, dimensions to 4 x 4;
// the element memory is not cleared.
`timescale 1ns / 1ps

module spiral_order_matrix_reader_top #(
    parameter int MAX_ROWS = spom_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = spom_pkg::MAX_COLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    spom_in_if.sink                        i_elem,
    spom_out_if.source                     o_res,
    input  logic                           i_cfg_we,
    input  logic [spom_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [spom_pkg::DIM_W-1:0]     i_cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic [spom_pkg::DIM_W-1:0] ROWS_MAX = spom_pkg::DIM_W'(MAX_ROWS);
    localparam logic [spom_pkg::DIM_W-1:0] COLS_MAX = spom_pkg::DIM_W'(MAX_COLS);

    spom_pkg::t_state           r_state, n_state;
    logic [spom_pkg::DIM_W-1:0] r_row_count, r_column_count;
    logic [AW-1:0]              r_load_cnt, n_load_cnt;
    logic                       r_last, n_last;

    logic [spom_pkg::DIM_W-1:0]  rows_eff, cols_eff;
    logic [spom_pkg::PROD_W-1:0] total;
    logic                        in_acc, out_acc, full;
    spom_pkg::t_walk_ctrl        walk_ctrl;
    logic [AW-1:0]               walk_addr;
    logic                        walk_last;
    logic [spom_pkg::VALUE_W-1:0] rd_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= spom_pkg::ROW_COUNT_RST;
            r_column_count <= spom_pkg::COLUMN_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spom_pkg::CFG_ROW_COUNT:    r_row_count    <= i_cfg_data;
                spom_pkg::CFG_COLUMN_COUNT: r_column_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp dimensions into 1..max
    always_comb begin
        if (r_row_count == '0) begin
            rows_eff = spom_pkg::DIM_W'(1);
        end else if (r_row_count > ROWS_MAX) begin
            rows_eff = ROWS_MAX;
        end else begin
            rows_eff = r_row_count;
        end
        if (r_column_count == '0) begin
            cols_eff = spom_pkg::DIM_W'(1);
        end else if (r_column_count > COLS_MAX) begin
            cols_eff = COLS_MAX;
        end else begin
            cols_eff = r_column_count;
        end
    end

    // matrix size and fill detection
    assign total   = spom_pkg::PROD_W'(rows_eff) * spom_pkg::PROD_W'(cols_eff);
    assign in_acc  = i_elem.valid && i_elem.ready;
    assign out_acc = o_res.valid && o_res.ready;
    assign full    = (spom_pkg::PROD_W'(r_load_cnt) + spom_pkg::PROD_W'(1)) >= total;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= spom_pkg::ST_LOAD;
            r_load_cnt <= '0;
            r_last     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_last     <= n_last;
        end
    end

    // sequencer next state and controls
    always_comb begin
        n_state         = r_state;
        n_load_cnt      = r_load_cnt;
        n_last          = r_last;
        walk_ctrl.start = 1'b0;
        walk_ctrl.step  = 1'b0;
        i_elem.ready    = 1'b0;
        o_res.valid     = 1'b0;
        case (r_state)
            spom_pkg::ST_LOAD: begin
                i_elem.ready = 1'b1;
                if (in_acc) begin
                    if (full) begin
                        n_load_cnt      = '0;
                        walk_ctrl.start = 1'b1;
                        n_state         = spom_pkg::ST_READ;
                    end else begin
                        n_load_cnt = r_load_cnt + AW'(1);
                    end
                end
            end
            spom_pkg::ST_READ: begin
                walk_ctrl.step = 1'b1;
                n_last         = walk_last;
                n_state        = spom_pkg::ST_SHOW;
            end
            spom_pkg::ST_SHOW: begin
                o_res.valid = 1'b1;
                if (out_acc) begin
                    n_state = r_last ? spom_pkg::ST_LOAD : spom_pkg::ST_READ;
                end
            end
            default: begin
                n_state = spom_pkg::ST_LOAD;
            end
        endcase
    end

    // result payload
    assign o_res.out_value = rd_data;
    assign o_res.out_last  = r_last;

    spom_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_load_cnt),
        .i_wdata (i_elem.element_value),
        .i_re    (r_state == spom_pkg::ST_READ),
        .i_raddr (walk_addr),
        .o_rdata (rd_data)
    );

    spom_walker #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .AW       (AW),
        .RW       (RW),
        .CW       (CW)
    ) u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (walk_ctrl),
        .i_rmax  (RW'(rows_eff - spom_pkg::DIM_W'(1))),
        .i_cmax  (CW'(cols_eff - spom_pkg::DIM_W'(1))),
        .i_cols  (AW'(cols_eff)),
        .o_addr  (walk_addr),
        .o_last  (walk_last)
    );

    // a filling element starts the read-out on the next cycle
    a_fill_starts_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && full) |=> (r_state == spom_pkg::ST_READ))
        else $error("filling element did not start the read-out");

    // the last result returns the block to loading
    a_last_returns_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_res.out_last) |=> (i_elem.ready && (r_load_cnt == '0)))
        else $error("block not loading after the last result");

    // load count stays cleared during the read-out
    a_count_clear_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != spom_pkg::ST_LOAD) |-> (r_load_cnt == '0))
        else $error("load count not cleared during read-out");

endmodule

// ----- dv/spom_spiral_checker.sv -----
// checker that predicts the spiral readout of each loaded matrix and compares every result
`timescale 1ns / 1ps

module spom_spiral_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    spom_in_if                             i_elem,
    spom_out_if                            i_res,
    input  logic                           i_cfg_we,
    input  logic [spom_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [spom_pkg::DIM_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    localparam int STORE_DEPTH = spom_pkg::MAX_ROWS_DEF * spom_pkg::MAX_COLS_DEF;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int OWED_DEPTH  = 2 * STORE_DEPTH;
    localparam int OWED_AW     = $clog2(OWED_DEPTH);

    // shadow of the dimension registers and the element store
    logic [spom_pkg::DIM_W-1:0]          row_reg;
    logic [spom_pkg::DIM_W-1:0]          col_reg;
    logic signed [spom_pkg::VALUE_W-1:0] element_mem [STORE_DEPTH];
    int unsigned                         fill_count;
    int                                  mismatches;

    // spiral results still owed by the block, oldest first
    logic signed [spom_pkg::VALUE_W-1:0] owed_value [OWED_DEPTH];
    logic                                owed_last [OWED_DEPTH];
    logic [OWED_AW-1:0]                  owed_wr_ptr;
    logic [OWED_AW-1:0]                  owed_rd_ptr;
    int                                  owed_count;

    // register value as the block uses it: zero acts as one, oversize as the maximum
    function automatic int unsigned dim_in_use(logic [spom_pkg::DIM_W-1:0] v,
                                               int unsigned maxv);
        if (v == '0)
            return 1;
        if (v > maxv)
            return maxv;
        return 32'(v);
    endfunction

    function automatic void owe_element(int unsigned idx, logic last);
        owed_value[owed_wr_ptr] = element_mem[STORE_AW'(idx)];
        owed_last[owed_wr_ptr]  = last;
        owed_wr_ptr             = owed_wr_ptr + OWED_AW'(1);
        owed_count++;
    endfunction

    // clockwise walk from the outer ring inward, single row or column only once
    task automatic owe_spiral(int unsigned rows, int unsigned cols);
        int          top_r;
        int          bot_r;
        int          left_c;
        int          right_c;
        int          i;
        int unsigned n;
        int unsigned total;
        top_r   = 0;
        bot_r   = rows - 1;
        left_c  = 0;
        right_c = cols - 1;
        n       = 0;
        total   = rows * cols;
        while (top_r <= bot_r && left_c <= right_c) begin
            for (i = left_c; i <= right_c; i++) begin
                n++;
                owe_element(top_r * cols + i, n == total);
            end
            for (i = top_r + 1; i <= bot_r - 1; i++) begin
                n++;
                owe_element(i * cols + right_c, n == total);
            end
            if (top_r != bot_r) begin
                for (i = right_c; i >= left_c; i--) begin
                    n++;
                    owe_element(bot_r * cols + i, n == total);
                end
            end
            if (left_c != right_c) begin
                for (i = bot_r - 1; i >= top_r + 1; i--) begin
                    n++;
                    owe_element(i * cols + left_c, n == total);
                end
            end
            top_r++;
            bot_r--;
            left_c++;
            right_c--;
        end
    endtask

    // store one element; the element that fills the matrix releases the spiral
    task automatic load_element(logic signed [spom_pkg::VALUE_W-1:0] v);
        int unsigned rows;
        int unsigned cols;
        rows = dim_in_use(row_reg, spom_pkg::MAX_ROWS_DEF);
        cols = dim_in_use(col_reg, spom_pkg::MAX_COLS_DEF);
        if (fill_count < STORE_DEPTH)
            element_mem[STORE_AW'(fill_count)] = v;
        if (fill_count + 1 < rows * cols) begin
            fill_count = (fill_count + 1) % STORE_DEPTH;
        end else begin
            fill_count = 0;
            owe_spiral(rows, cols);
        end
    endtask

    // watch register writes, element and result transactions
    always @(posedge i_clk) begin : p_check
        logic signed [spom_pkg::VALUE_W-1:0] want_value;
        logic                                want_last;
        if (!i_rst_n) begin
            row_reg     = spom_pkg::ROW_COUNT_RST;
            col_reg     = spom_pkg::COLUMN_COUNT_RST;
            fill_count  = 0;
            owed_wr_ptr = '0;
            owed_rd_ptr = '0;
            owed_count  = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == spom_pkg::CFG_ROW_COUNT)
                    row_reg = i_cfg_data;
                else if (i_cfg_idx == spom_pkg::CFG_COLUMN_COUNT)
                    col_reg = i_cfg_data;
            end
            if (i_elem.valid && i_elem.ready)
                load_element(i_elem.element_value);
            if (i_res.valid && i_res.ready) begin
                if (owed_count == 0) begin
                    $error("unexpected result transaction: out_value %0d out_last %0b",
                           i_res.out_value, i_res.out_last);
                    mismatches++;
                end else begin
                    want_value  = owed_value[owed_rd_ptr];
                    want_last   = owed_last[owed_rd_ptr];
                    owed_rd_ptr = owed_rd_ptr + OWED_AW'(1);
                    owed_count--;
                    if (i_res.out_value !== want_value) begin
                        $error("out_value mismatch: expected %0d, got %0d",
                               want_value, i_res.out_value);
                        mismatches++;
                    end
                    if (i_res.out_last !== want_last) begin
                        $error("out_last mismatch: expected %0b, got %0b",
                               want_last, i_res.out_last);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= owed_count;
        o_fail_count <= mismatches;
    end

endmodule

// ----- dv/spiral_order_matrix_reader_top_tb.sv -----
// testbench top: clock, reset, element and register stimulus, result backpressure, verdict
`timescale 1ns / 1ps

module spiral_order_matrix_reader_top_tb;

    localparam int ELEMENT_BUDGET = 365;
    localparam int QUIET_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;

    // pacing of the two channels
    typedef enum logic [1:0] {
        PACE_STEADY,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } t_pace;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [spom_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [spom_pkg::DIM_W-1:0]     cfg_data;
    logic [spom_pkg::DIM_W-1:0]     row_setting;
    logic [spom_pkg::DIM_W-1:0]     col_setting;
    int                             fail_count;
    int                             pending;
    int                             gap_pct;
    int                             stall_pct;
    int                             quiet_cycles;
    int                             elements_sent;

    spom_in_if  elem_if ();
    spom_out_if res_if ();

    spiral_order_matrix_reader_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_elem     (elem_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    spom_spiral_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_elem       (elem_if),
        .i_res        (res_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // result backpressure
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((elem_if.valid && elem_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("spiral_order_matrix_reader_top_tb: done, errors");
            $finish;
        end
    end

    task automatic set_pace(t_pace p);
        case (p)
            PACE_STEADY: begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            PACE_SEND_IDLE: begin
                gap_pct   = 73;
                stall_pct = 0;
            end
            PACE_RECV_STALL: begin
                gap_pct   = 0;
                stall_pct = 73;
            end
            default: begin
                gap_pct   = 6;
                stall_pct = 6;
            end
        endcase
    endtask

    function automatic int unsigned dim_in_use(logic [spom_pkg::DIM_W-1:0] v,
                                               int unsigned maxv);
        if (v == '0)
            return 1;
        if (v > maxv)
            return maxv;
        return 32'(v);
    endfunction

    function automatic int unsigned matrix_size();
        return dim_in_use(row_setting, spom_pkg::MAX_ROWS_DEF) *
               dim_in_use(col_setting, spom_pkg::MAX_COLS_DEF);
    endfunction

    // mostly random words, sometimes the extremes of the signed range
    function automatic logic signed [spom_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // hold the sender until every owed result is out and the block has settled
    task automatic wait_drained();
        elem_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dim(logic [spom_pkg::CFG_IDX_W-1:0] idx,
                             logic [spom_pkg::DIM_W-1:0] data);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == spom_pkg::CFG_ROW_COUNT)
            row_setting = data;
        else
            col_setting = data;
    endtask

    task automatic set_dims(logic [spom_pkg::DIM_W-1:0] rows,
                            logic [spom_pkg::DIM_W-1:0] cols);
        write_dim(spom_pkg::CFG_ROW_COUNT, rows);
        write_dim(spom_pkg::CFG_COLUMN_COUNT, cols);
    endtask

    // one element transaction, with idle cycles ahead of it as the pace asks
    task automatic send_element(logic signed [spom_pkg::VALUE_W-1:0] v);
        while ($urandom_range(99) < gap_pct) begin
            elem_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        elem_if.valid         <= 1'b1;
        elem_if.element_value <= v;
        do @(posedge i_clk); while (!elem_if.ready);
        elements_sent++;
    endtask

    task automatic send_elements(int unsigned n);
        repeat (n) send_element(pick_value());
    endtask

    // stimulus
    initial begin : p_stim
        int          random_start;
        int          phase;
        int unsigned loads;
        int unsigned part;
        int unsigned grown;
        logic        big;
        elem_if.valid         <= 1'b0;
        elem_if.element_value <= '0;
        cfg_we                <= 1'b0;
        cfg_idx               <= spom_pkg::CFG_ROW_COUNT;
        cfg_data              <= '0;
        i_rst_n               <= 1'b0;
        row_setting   = spom_pkg::ROW_COUNT_RST;
        col_setting   = spom_pkg::COLUMN_COUNT_RST;
        elements_sent = 0;
        phase         = 0;
        set_pace(PACE_STEADY);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset dimensions, extremes of the element range first
        send_element(32'sh8000_0000);
        send_element(32'sh7FFF_FFFF);
        send_element('0);
        send_element(-32'sd1);
        send_elements(12);

        // zero registers act as a 1 x 1 matrix
        set_dims('0, '0);
        send_element(pick_value());

        // shrink mid-load so the fill count just reaches the new size
        set_dims(4'd2, 4'd3);
        send_elements(2);
        write_dim(spom_pkg::CFG_ROW_COUNT, 4'd1);
        send_element(pick_value());

        // shrink mid-load below the fill count already reached
        set_dims(4'd3, 4'd3);
        send_elements(4);
        set_dims(4'd1, 4'd2);
        send_element(pick_value());

        // random phases, mostly small matrices
        random_start = elements_sent;
        while (elements_sent - random_start < ELEMENT_BUDGET) begin
            set_pace(t_pace'(phase % 4));
            phase++;
            big = 1'b0;
            case ($urandom_range(15))
                0: begin
                    set_dims(spom_pkg::DIM_W'($urandom_range(8, 15)),
                             spom_pkg::DIM_W'($urandom_range(8, 15)));
                    big = 1'b1;
                end
                1, 2: set_dims(spom_pkg::DIM_W'($urandom_range(9, 15)),
                               spom_pkg::DIM_W'($urandom_range(0, 3)));
                3, 4: set_dims(spom_pkg::DIM_W'($urandom_range(0, 3)),
                               spom_pkg::DIM_W'($urandom_range(9, 15)));
                default: set_dims(spom_pkg::DIM_W'($urandom_range(0, 5)),
                                  spom_pkg::DIM_W'($urandom_range(0, 5)));
            endcase
            loads = big ? 1 : $urandom_range(1, 3);
            repeat (loads) begin
                if (!big && matrix_size() > 1 && $urandom_range(4) == 0) begin
                    // change the dimensions part way through a load
                    part = $urandom_range(1, matrix_size() - 1);
                    send_elements(part);
                    set_dims(spom_pkg::DIM_W'($urandom_range(0, 5)),
                             spom_pkg::DIM_W'($urandom_range(0, 5)));
                    grown = matrix_size();
                    send_elements(grown > part ? grown - part : 1);
                end else begin
                    send_elements(matrix_size());
                end
                if ($urandom_range(3) == 0)
                    wait_drained();
            end
        end

        // drain and give the verdict
        set_pace(PACE_STEADY);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("spiral_order_matrix_reader_top_tb: done, clean");
        end else begin
            if (pending != 0)
                $error("%0d expected results never arrived", pending);
            $display("spiral_order_matrix_reader_top_tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/spom_pkg.sv
hw/rtl/spom_if.sv
hw/rtl/spom_store.sv
hw/rtl/spom_walker.sv
hw/rtl/spiral_order_matrix_reader_top.sv
dv/spom_spiral_checker.sv
dv/spiral_order_matrix_reader_top_tb.sv
